### rtl/glsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the gradient line stepper.
package glsd_pkg;

    localparam int XY_BITS     = 12;
    localparam int Z_BITS      = 16;
    localparam int L_BITS      = (Z_BITS > XY_BITS) ? Z_BITS : XY_BITS;
    localparam int NUM_BITS    = 2 * L_BITS;
    localparam int CNT_BITS    = $clog2(L_BITS + 1);
    localparam int CH_COUNT    = 4;
    localparam int COORD_LANES = 3;
    localparam int LANES       = COORD_LANES + CH_COUNT;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [XY_BITS-1:0]       start_x;
        logic [XY_BITS-1:0]       start_y;
        logic signed [Z_BITS-1:0] start_z;
        logic [XY_BITS-1:0]       end_x;
        logic [XY_BITS-1:0]       end_y;
        logic signed [Z_BITS-1:0] end_z;
        logic [31:0]              color_start;
        logic [31:0]              color_end;
    } glsd_in_t;

    typedef struct packed {
        logic [XY_BITS-1:0]       pix_x;
        logic [XY_BITS-1:0]       pix_y;
        logic signed [Z_BITS-1:0] pix_z;
        logic [31:0]              pix_color;
        logic                     last_pixel;
    } glsd_out_t;

    typedef struct packed {
        logic [XY_BITS-1:0] origin_x;
        logic [XY_BITS-1:0] origin_y;
        logic [Z_BITS-1:0]  origin_z;
        logic [L_BITS-1:0]  mag_x;
        logic [L_BITS-1:0]  mag_y;
        logic [L_BITS-1:0]  mag_z;
        logic               neg_x;
        logic               neg_y;
        logic               neg_z;
        logic [31:0]        first_color;
        logic [31:0]        second_color;
        logic [L_BITS-1:0]  span_len;
        logic [L_BITS-1:0]  step_index;
        logic               last_step;
    } glsd_job_t;

endpackage

### rtl/glsd_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, holds the line setup and issues one pixel job per step.
module glsd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  glsd_pkg::glsd_in_t   s_data,
    input  logic                 q_full,
    output logic                 q_push,
    output glsd_pkg::glsd_job_t  q_job
);
    import glsd_pkg::*;

    logic [XY_BITS:0]  dx, dy, ax, ay;
    logic [Z_BITS:0]   dz, az;
    logic [L_BITS-1:0] mag_x, mag_y, mag_z, span;
    logic              load_acc;
    glsd_job_t         line_reg, line_next;
    logic [L_BITS-1:0] n_reg;
    logic              active_reg;

    assign s_ready  = !q_full;
    assign load_acc = s_valid && s_ready && (s_data.req_type == REQ_LOAD);
    assign q_push   = s_valid && s_ready && (s_data.req_type == REQ_STEP) && active_reg;

    always_comb begin
        dx = {1'b0, s_data.end_x} - {1'b0, s_data.start_x};
        dy = {1'b0, s_data.end_y} - {1'b0, s_data.start_y};
        dz = {s_data.end_z[Z_BITS-1], s_data.end_z} - {s_data.start_z[Z_BITS-1], s_data.start_z};
        ax = dx[XY_BITS] ? (~dx + 1'b1) : dx;
        ay = dy[XY_BITS] ? (~dy + 1'b1) : dy;
        az = dz[Z_BITS] ? (~dz + 1'b1) : dz;
        mag_x = L_BITS'(ax[XY_BITS-1:0]);
        mag_y = L_BITS'(ay[XY_BITS-1:0]);
        mag_z = L_BITS'(az[Z_BITS-1:0]);
        span = mag_x;
        if (mag_y > span) begin
            span = mag_y;
        end
        if (mag_z > span) begin
            span = mag_z;
        end

        line_next              = '0;
        line_next.origin_x     = s_data.start_x;
        line_next.origin_y     = s_data.start_y;
        line_next.origin_z     = s_data.start_z;
        line_next.mag_x        = mag_x;
        line_next.mag_y        = mag_y;
        line_next.mag_z        = mag_z;
        line_next.neg_x        = dx[XY_BITS];
        line_next.neg_y        = dy[XY_BITS];
        line_next.neg_z        = dz[Z_BITS];
        line_next.first_color  = s_data.color_start;
        line_next.second_color = s_data.color_end;
        line_next.span_len     = span;
    end

    always_comb begin
        q_job            = line_reg;
        q_job.step_index = n_reg;
        q_job.last_step  = (n_reg == line_reg.span_len);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            n_reg      <= '0;
        end else if (load_acc) begin
            active_reg <= 1'b1;
            n_reg      <= '0;
        end else if (q_push) begin
            if (n_reg == line_reg.span_len) begin
                active_reg <= 1'b0;
            end else begin
                n_reg <= n_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_acc) begin
            line_reg <= line_next;
        end
    end

endmodule

### rtl/glsd_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the pixel unit.
module glsd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  glsd_pkg::glsd_job_t  push_job,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output glsd_pkg::glsd_job_t  head_job
);
    import glsd_pkg::*;

    glsd_job_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign full      = (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/glsd_back.sv
`timescale 1ns / 1ps
// Pixel unit: scales the deltas and blends the colors with bit-serial divides run in parallel on all lanes.
module glsd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  glsd_pkg::glsd_job_t  q_job,
    output logic                 m_valid,
    input  logic                 m_ready,
    output glsd_pkg::glsd_out_t  m_data
);
    import glsd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} state_t;

    state_t             state_reg;
    glsd_job_t          job_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [L_BITS-1:0]  rem_reg [LANES];
    logic [L_BITS-1:0]  quo_reg [LANES];
    logic [L_BITS-1:0]  rem_next [LANES];
    logic [L_BITS-1:0]  quo_next [LANES];
    logic [NUM_BITS-1:0] num [LANES];
    logic [L_BITS:0]    trial [LANES];
    logic [L_BITS-1:0]  lane_mag [COORD_LANES];
    logic [L_BITS-1:0]  rest;
    logic [L_BITS-1:0]  sx, sy, sz;
    logic               out_free;
    logic               m_valid_reg;
    glsd_out_t          m_data_reg, result;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        lane_mag[0] = job_reg.mag_x;
        lane_mag[1] = job_reg.mag_y;
        lane_mag[2] = job_reg.mag_z;
        rest = job_reg.span_len - job_reg.step_index;
        for (int i = 0; i < COORD_LANES; i++) begin
            num[i] = NUM_BITS'(lane_mag[i]) * NUM_BITS'(job_reg.step_index);
        end
        for (int k = 0; k < CH_COUNT; k++) begin
            num[COORD_LANES + k] =
                NUM_BITS'(job_reg.first_color[8*k +: 8]) * NUM_BITS'(rest) +
                NUM_BITS'(job_reg.second_color[8*k +: 8]) * NUM_BITS'(job_reg.step_index);
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            trial[i] = {rem_reg[i], quo_reg[i][L_BITS-1]};
            if (trial[i] >= {1'b0, job_reg.span_len}) begin
                rem_next[i] = L_BITS'(trial[i] - {1'b0, job_reg.span_len});
                quo_next[i] = {quo_reg[i][L_BITS-2:0], 1'b1};
            end else begin
                rem_next[i] = trial[i][L_BITS-1:0];
                quo_next[i] = {quo_reg[i][L_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        sx = job_reg.neg_x ? (~quo_reg[0] + 1'b1) : quo_reg[0];
        sy = job_reg.neg_y ? (~quo_reg[1] + 1'b1) : quo_reg[1];
        sz = job_reg.neg_z ? (~quo_reg[2] + 1'b1) : quo_reg[2];
        result.pix_x      = job_reg.origin_x + sx[XY_BITS-1:0];
        result.pix_y      = job_reg.origin_y + sy[XY_BITS-1:0];
        result.pix_z      = job_reg.origin_z + sz[Z_BITS-1:0];
        result.last_pixel = job_reg.last_step;
        if (job_reg.span_len == '0) begin
            result.pix_color = job_reg.first_color;
        end else begin
            for (int k = 0; k < CH_COUNT; k++) begin
                result.pix_color[8*k +: 8] = quo_reg[COORD_LANES + k][7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        job_reg   <= q_job;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    for (int i = 0; i < LANES; i++) begin
                        rem_reg[i] <= num[i][NUM_BITS-1:L_BITS];
                        quo_reg[i] <= num[i][L_BITS-1:0];
                    end
                    cnt_reg <= '0;
                    if (job_reg.span_len == '0) begin
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    for (int i = 0; i < LANES; i++) begin
                        rem_reg[i] <= rem_next[i];
                        quo_reg[i] <= quo_next[i];
                    end
                    if (cnt_reg == CNT_BITS'(L_BITS - 1)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_data_reg  <= result;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/gradient_line_stepper_3d.sv
`timescale 1ns / 1ps
// Top level of the 3D line stepper with color gradient.
//
//   Channel   Direction  Handshake         Payload
//   s_        in         s_valid/s_ready   glsd_in_t: load or step item
//   m_        out        m_valid/m_ready   glsd_out_t: one pixel per queued step item
//
// A load item sets up the line and issues no pixel; a step item on an idle stepper is dropped.
// Each pixel passes through the pixel unit's states idle, multiply, divide and output;
// its divider retires one quotient bit per cycle on all seven lanes;
// a pixel of a zero-span line skips the divider.
// A two-entry job queue lets the front end keep accepting while the pixel unit works.
// Reset is synchronous and clears the line state, the queue and the output valid.
// s_ready drops only while the queue is full; the pixel unit waits on m_ready.
module gradient_line_stepper_3d (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  glsd_pkg::glsd_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output glsd_pkg::glsd_out_t  m_data
);
    import glsd_pkg::*;

    logic      q_full, q_push, q_pop, q_valid;
    glsd_job_t push_job, head_job;

    glsd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    glsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_job  (head_job)
    );

    glsd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_job   (head_job),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### rtl/glsd_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the line stepper and their binding to the top level.
module glsd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input glsd_pkg::glsd_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input glsd_pkg::glsd_out_t m_data
);
    import glsd_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result item changed while stalled");

    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_ready && (s_data.req_type == REQ_STEP)))
        else $error("queue filled without a step item");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind gradient_line_stepper_3d glsd_checker u_glsd_checker (.*);
